// ===== sv/playfield_sprite_video_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the playfield and sprite video generator
// Shared helpers for concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef PLAYFIELD_SPRITE_VIDEO_GENERATOR_MACROS_SVH
`define PLAYFIELD_SPRITE_VIDEO_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PFSV_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pfsv_pkg.sv =====
// ----------------------------------------------------------------------------
// Package for the playfield and sprite video generator
// Shared types, register map codes and small lookup functions.
// ----------------------------------------------------------------------------
package pfsv_pkg;

    localparam int LINE_PIXELS    = 228;
    localparam int BLANK_PIXELS   = 68;
    localparam int VISIBLE_PIXELS = 160;
    localparam int HALF_PIXELS    = VISIBLE_PIXELS / 2;

    // Item kinds.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Write register map.
    localparam logic [5:0] A_VSYNC  = 6'd0;
    localparam logic [5:0] A_VBLANK = 6'd1;
    localparam logic [5:0] A_WSYNC  = 6'd2;
    localparam logic [5:0] A_RSYNC  = 6'd3;
    localparam logic [5:0] A_NUSIZ0 = 6'd4;
    localparam logic [5:0] A_NUSIZ1 = 6'd5;
    localparam logic [5:0] A_COLUP0 = 6'd6;
    localparam logic [5:0] A_COLUBK = 6'd9;
    localparam logic [5:0] A_CTRLPF = 6'd10;
    localparam logic [5:0] A_REFP0  = 6'd11;
    localparam logic [5:0] A_REFP1  = 6'd12;
    localparam logic [5:0] A_PF0    = 6'd13;
    localparam logic [5:0] A_PF1    = 6'd14;
    localparam logic [5:0] A_PF2    = 6'd15;
    localparam logic [5:0] A_RESP0  = 6'd16;
    localparam logic [5:0] A_RESP1  = 6'd17;
    localparam logic [5:0] A_RESM0  = 6'd18;
    localparam logic [5:0] A_RESM1  = 6'd19;
    localparam logic [5:0] A_RESBL  = 6'd20;
    localparam logic [5:0] A_GRP0   = 6'd27;
    localparam logic [5:0] A_GRP1   = 6'd28;
    localparam logic [5:0] A_ENAM0  = 6'd29;
    localparam logic [5:0] A_ENAM1  = 6'd30;
    localparam logic [5:0] A_ENABL  = 6'd31;
    localparam logic [5:0] A_HMP0   = 6'd32;
    localparam logic [5:0] A_HMBL   = 6'd36;
    localparam logic [5:0] A_VDELP0 = 6'd37;
    localparam logic [5:0] A_VDELP1 = 6'd38;
    localparam logic [5:0] A_VDELBL = 6'd39;
    localparam logic [5:0] A_RESMP0 = 6'd40;
    localparam logic [5:0] A_RESMP1 = 6'd41;
    localparam logic [5:0] A_HMOVE  = 6'd42;
    localparam logic [5:0] A_HMCLR  = 6'd43;
    localparam logic [5:0] A_CXCLR  = 6'd44;

    // Read map (low four address bits).
    localparam logic [3:0] R_INPT4 = 4'd12;
    localparam logic [3:0] R_INPT5 = 4'd13;

    // Configuration register indexes.
    localparam logic CFG_PLAYER_OFS = 1'b0;
    localparam logic CFG_SMALL_OFS  = 1'b1;

    // Architectural state of the video generator.
    typedef struct packed {
        logic [7:0]       line_cnt;
        logic [19:0]      pf_left;
        logic             mirror;
        logic             score;
        logic             pf_pri;
        logic [3:0][7:0]  colour;
        logic [1:0][8:0]  p_pos;
        logic [1:0][7:0]  p_shape;
        logic [1:0][7:0]  p_held;
        logic [1:0]       p_refl;
        logic [1:0]       p_vdel;
        logic [1:0][8:0]  copy_pat;
        logic [1:0][2:0]  stretch;
        logic [1:0][8:0]  m_pos;
        logic [1:0][3:0]  m_width;
        logic [1:0]       m_on;
        logic [8:0]       bl_pos;
        logic [3:0]       bl_width;
        logic [2:0]       bl_flags;   // enable, held, delay
        logic [4:0][3:0]  motion;
        logic [1:0]       sync;       // vsync, vblank
        logic [14:0]      coll;
    } vid_state_t;

    // Side results of a register write.
    typedef struct packed {
        logic       frame_sync;
        logic [6:0] stall;
    } wr_result_t;

    // Pixel stage results.
    typedef struct packed {
        logic        blank;
        logic [7:0]  color;
        logic [14:0] hits;
    } pix_result_t;

    function automatic logic [8:0] copy_lut(input logic [2:0] n);
        case (n)
            3'd1:    copy_lut = 9'b000000101;
            3'd2:    copy_lut = 9'b000010001;
            3'd3:    copy_lut = 9'b000010101;
            3'd4:    copy_lut = 9'b100000001;
            3'd6:    copy_lut = 9'b100010001;
            default: copy_lut = 9'd0;
        endcase
    endfunction

    function automatic logic [2:0] stretch_lut(input logic [2:0] n);
        case (n)
            3'd5:    stretch_lut = 3'd2;
            3'd7:    stretch_lut = 3'd4;
            default: stretch_lut = 3'd1;
        endcase
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

    // Position after a motion strobe, kept within the visible line.
    function automatic logic [8:0] moved(input logic [8:0] pos, input logic [3:0] nib);
        logic signed [10:0] v;
        v = $signed({2'b00, pos}) - $signed({{7{nib[3]}}, nib});
        if (v < 0) begin
            v = v + 11'sd160;
        end else if (v >= 11'sd480) begin
            v = v - 11'sd480;
        end else if (v >= 11'sd320) begin
            v = v - 11'sd320;
        end else if (v >= 11'sd160) begin
            v = v - 11'sd160;
        end
        return v[8:0];
    endfunction

    // Collision or fire-button read byte.
    function automatic logic [7:0] read_byte(input logic [14:0] c, input logic [3:0] a,
                                             input logic f0, input logic f1);
        logic [7:0] r;
        r = 8'd0;
        case (a)
            4'd0: r = {c[0],  c[1],  6'h02};
            4'd1: r = {c[2],  c[3],  6'h02};
            4'd2: r = {c[4],  c[5],  6'h02};
            4'd3: r = {c[6],  c[7],  6'h02};
            4'd4: r = {c[8],  c[9],  6'h02};
            4'd5: r = {c[10], c[11], 6'h02};
            4'd6: r = {c[12], 1'b0,  6'h02};
            4'd7: r = {c[13], c[14], 6'h02};
            R_INPT4: r = {~f0, 7'd0};
            R_INPT5: r = {~f1, 7'd0};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/pfsv_pixel.sv =====
// ----------------------------------------------------------------------------
// Pixel generator
// Object hit tests, priority colour choice and collision hits for one tick.
// ----------------------------------------------------------------------------
module pfsv_pixel (
    input  pfsv_pkg::vid_state_t  st,
    output pfsv_pkg::pix_result_t res
);
    import pfsv_pkg::*;

    logic signed [8:0]  x;
    logic signed [10:0] d;
    logic [10:0]        lim;
    logic [2:0]         idx;
    logic [1:0]         sh;
    logic [7:0]         shown;
    logic [7:0]         cidx;
    logic [1:0]         p_hit, m_hit;
    logic               bl, bl_en, pf;
    logic [39:0]        field;
    logic [19:0]        right;
    logic [7:0]         pfc;
    logic [10:0]        bd;

    assign x = $signed({1'b0, st.line_cnt}) - 9'sd68;

    // Players and missiles.
    always_comb begin
        d     = '0;
        lim   = '0;
        idx   = '0;
        sh    = '0;
        shown = '0;
        cidx  = '0;
        for (int k = 0; k < 2; k++) begin
            p_hit[k] = 1'b0;
            m_hit[k] = 1'b0;
            shown = st.p_vdel[k] ? st.p_held[k] : st.p_shape[k];
            d = {{2{x[8]}}, x} - $signed({2'b00, st.p_pos[k]});
            sh = (st.stretch[k] == 3'd4) ? 2'd2 : ((st.stretch[k] == 3'd2) ? 2'd1 : 2'd0);
            if (!d[10]) begin
                if (st.copy_pat[k] == 9'd0) begin
                    lim = 11'd8 << sh;
                    idx = 3'(d >>> sh);
                    if (d < $signed(lim)) begin
                        p_hit[k] = st.p_refl[k] ? shown[idx] : shown[3'd7 - idx];
                    end
                end else begin
                    cidx = d[10:3];
                    idx  = d[2:0];
                    if (cidx < 8'd9 && st.copy_pat[k][cidx[3:0]]) begin
                        p_hit[k] = st.p_refl[k] ? shown[idx] : shown[3'd7 - idx];
                    end
                end
            end
            d = {{2{x[8]}}, x} - $signed({2'b00, st.m_pos[k]});
            if (st.m_on[k] && !d[10]) begin
                if (st.copy_pat[k] == 9'd0) begin
                    m_hit[k] = d < $signed({7'd0, st.m_width[k]});
                end else begin
                    cidx = d[10:3];
                    if (cidx < 8'd9 && st.copy_pat[k][cidx[3:0]]) begin
                        m_hit[k] = {1'b0, d[2:0]} < st.m_width[k];
                    end
                end
            end
        end
    end

    // Ball and playfield.
    always_comb begin
        bl_en = st.bl_flags[2] ? st.bl_flags[1] : st.bl_flags[0];
        bd    = {{2{x[8]}}, x} - $signed({2'b00, st.bl_pos});
        bl    = bl_en && !bd[10] && (bd < $signed({7'd0, st.bl_width}));
        right = st.pf_left;
        if (st.mirror) begin
            for (int i = 0; i < 20; i++) begin
                right[19 - i] = st.pf_left[i];
            end
        end
        field = {right, st.pf_left};
        pf    = !x[8] && (x[7:2] < 6'd40) && field[x[7:2]];
        pfc   = st.score ? ((x < 9'sd80) ? st.colour[0] : st.colour[1]) : st.colour[2];
    end

    // Priority colour and collision hits, suppressed in vertical blank.
    always_comb begin
        res.blank = st.sync[1];
        res.hits  = '0;
        res.color = '0;
        if (!st.sync[1]) begin
            res.hits = {m_hit[0] & m_hit[1], p_hit[0] & p_hit[1], bl & pf,
                        m_hit[1] & bl, m_hit[1] & pf, m_hit[0] & bl, m_hit[0] & pf,
                        p_hit[1] & bl, p_hit[1] & pf, p_hit[0] & bl, p_hit[0] & pf,
                        m_hit[1] & p_hit[1], m_hit[1] & p_hit[0],
                        m_hit[0] & p_hit[0], m_hit[0] & p_hit[1]};
            if (st.pf_pri && pf) begin
                res.color = pfc;
            end else if (st.pf_pri && bl) begin
                res.color = st.colour[2];
            end else if (p_hit[0] || m_hit[0]) begin
                res.color = st.colour[0];
            end else if (p_hit[1] || m_hit[1]) begin
                res.color = st.colour[1];
            end else if (pf) begin
                res.color = pfc;
            end else if (bl) begin
                res.color = st.colour[2];
            end else begin
                res.color = st.colour[3];
            end
        end
    end

endmodule

// ===== sv/pfsv_regfile.sv =====
// ----------------------------------------------------------------------------
// Register file
// Holds the video state; applies ticks, register writes and configuration.
// ----------------------------------------------------------------------------
module pfsv_regfile (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_sel,
    input  logic [3:0]            cfg_val,
    input  logic                  fire,
    input  logic [1:0]            op,
    input  logic [5:0]            addr,
    input  logic [7:0]            wdata,
    input  logic [14:0]           hits,
    output pfsv_pkg::vid_state_t  st,
    output pfsv_pkg::wr_result_t  wres
);
    import pfsv_pkg::*;

    vid_state_t  st_reg, st_next;
    vid_state_t  st_rst;
    logic [3:0]  p_ofs_reg, s_ofs_reg;
    logic [8:0]  p_reset, s_reset;
    logic [7:0]  remain;
    logic [15:0] prod;
    logic [6:0]  quot;
    logic [7:0]  lc_inc;
    logic [3:0]  add;

    assign st = st_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_ofs_reg <= '0;
            s_ofs_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_sel == CFG_PLAYER_OFS) begin
                p_ofs_reg <= cfg_val;
            end else begin
                s_ofs_reg <= cfg_val;
            end
        end
    end

    // Reset strobe positions; divide-by-three for the line sync stall.
    always_comb begin
        p_reset = (st_reg.line_cnt < 8'(BLANK_PIXELS)) ? 9'd3 :
                  9'(st_reg.line_cnt - 8'(BLANK_PIXELS)) + {5'd0, p_ofs_reg};
        s_reset = (st_reg.line_cnt < 8'(BLANK_PIXELS)) ? 9'd2 :
                  9'(st_reg.line_cnt - 8'(BLANK_PIXELS)) + {5'd0, s_ofs_reg};
        remain  = 8'(LINE_PIXELS) - st_reg.line_cnt;
        prod    = {8'd0, remain} * 16'd171;
        quot    = prod[15:9];
        lc_inc  = (st_reg.line_cnt == 8'(LINE_PIXELS - 1)) ? 8'd0 : st_reg.line_cnt + 8'd1;
    end

    // Next state for the accepted item.
    always_comb begin
        st_next = st_reg;
        wres    = '0;
        add     = '0;
        if (fire && op == OP_TICK) begin
            st_next.coll     = st_reg.coll | hits;
            st_next.line_cnt = lc_inc;
        end else if (fire && op == OP_WRITE) begin
            unique case (addr) inside
                A_VSYNC: begin
                    wres.frame_sync = st_reg.sync[0] && !wdata[1];
                    st_next.sync[0] = wdata[1];
                end
                A_VBLANK: st_next.sync[1] = wdata[1];
                A_WSYNC: begin
                    if (st_reg.line_cnt != 8'd0) begin
                        wres.stall = quot;
                    end
                end
                A_RSYNC: st_next.line_cnt = 8'(LINE_PIXELS - 3);
                A_NUSIZ0, A_NUSIZ1: begin
                    st_next.m_width[addr[0]]  = 4'd1 << wdata[5:4];
                    st_next.copy_pat[addr[0]] = copy_lut(wdata[2:0]);
                    st_next.stretch[addr[0]]  = stretch_lut(wdata[2:0]);
                end
                [A_COLUP0:A_COLUBK]: st_next.colour[2'(addr - A_COLUP0)] = wdata;
                A_CTRLPF: begin
                    st_next.mirror   = wdata[0];
                    st_next.score    = wdata[1];
                    st_next.pf_pri   = wdata[2];
                    st_next.bl_width = 4'd1 << wdata[5:4];
                end
                A_REFP0: st_next.p_refl[0] = wdata[3];
                A_REFP1: st_next.p_refl[1] = wdata[3];
                A_PF0:   st_next.pf_left[3:0]   = wdata[7:4];
                A_PF1:   st_next.pf_left[11:4]  = rev8(wdata);
                A_PF2:   st_next.pf_left[19:12] = wdata;
                A_RESP0: st_next.p_pos[0] = p_reset;
                A_RESP1: st_next.p_pos[1] = p_reset;
                A_RESM0: st_next.m_pos[0] = s_reset;
                A_RESM1: st_next.m_pos[1] = s_reset;
                A_RESBL: st_next.bl_pos   = s_reset;
                A_GRP0: begin
                    st_next.p_shape[0] = wdata;
                    st_next.p_held[1]  = st_reg.p_shape[1];
                end
                A_GRP1: begin
                    st_next.p_shape[1]  = wdata;
                    st_next.p_held[0]   = st_reg.p_shape[0];
                    st_next.bl_flags[1] = st_reg.bl_flags[0];
                end
                A_ENAM0: st_next.m_on[0] = wdata[1];
                A_ENAM1: st_next.m_on[1] = wdata[1];
                A_ENABL: st_next.bl_flags[0] = wdata[1];
                [A_HMP0:A_HMBL]: st_next.motion[3'(addr - A_HMP0)] = wdata[7:4];
                A_VDELP0: st_next.p_vdel[0] = wdata[1];
                A_VDELP1: st_next.p_vdel[1] = wdata[1];
                A_VDELBL: st_next.bl_flags[2] = wdata[1];
                A_RESMP0, A_RESMP1: begin
                    add = (st_reg.stretch[addr[0]] == 3'd4) ? 4'd10 :
                          ((st_reg.stretch[addr[0]] == 3'd2) ? 4'd6 : 4'd3);
                    if (wdata[1]) begin
                        st_next.m_pos[addr[0]] = st_reg.p_pos[addr[0]] + {5'd0, add};
                    end
                end
                A_HMOVE: begin
                    st_next.p_pos[0] = moved(st_reg.p_pos[0], st_reg.motion[0]);
                    st_next.p_pos[1] = moved(st_reg.p_pos[1], st_reg.motion[1]);
                    st_next.m_pos[0] = moved(st_reg.m_pos[0], st_reg.motion[2]);
                    st_next.m_pos[1] = moved(st_reg.m_pos[1], st_reg.motion[3]);
                    st_next.bl_pos   = moved(st_reg.bl_pos, st_reg.motion[4]);
                end
                A_HMCLR: st_next.motion = '0;
                A_CXCLR: st_next.coll   = '0;
                default: ;
            endcase
        end
    end

    // Power-up values of the video state.
    always_comb begin
        st_rst          = '0;
        st_rst.stretch  = {3'd1, 3'd1};
        st_rst.m_width  = {4'd1, 4'd1};
        st_rst.bl_width = 4'd1;
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= st_rst;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== sv/playfield_sprite_video_generator.sv =====
// ----------------------------------------------------------------------------
// Playfield and sprite video generator
// Top level: input register, pixel and register logic, result register.
// ----------------------------------------------------------------------------
// Items (pixel tick, register write, register read) enter on the s_ stream
// and each gives exactly one result on the m_ stream, in order.
// An accepted request is held in the input register and processed from there
// against the current state once the result register is free; the result is
// then registered in the result register, which drives m_tvalid.
// Throughput is one item per cycle: the input register refills while the
// result register is taken, limited only by the receiver.
// When the receiver stalls, the result register holds, the input register
// holds its item, and s_tready drops once both are full.
// The cfg_ channel writes the two reset-offset registers; the user must write
// them only while the block is idle, which the block itself does not enforce; cfg_ready is always high.
// Reset (aresetn low, synchronous) clears both stream stages and returns all
// video state to its power-up values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module playfield_sprite_video_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode, reg_addr, write_data, fire_zero, fire_one
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_valid, pixel_blank, pixel_x, pixel_color,
                                   // read_data, frame_sync, stall_cycles
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);
    import pfsv_pkg::*;

    `include "playfield_sprite_video_generator_macros.svh"

    logic        in_valid_reg, in_valid_next;
    logic [17:0] in_data_reg;
    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg, out_data_next;
    logic        fire;
    logic [1:0]  op;
    logic [5:0]  addr;
    logic [7:0]  wdata;
    vid_state_t  st;
    wr_result_t  wres;
    pix_result_t pres;
    logic [8:0]  px;

    assign op    = in_data_reg[1:0];
    assign addr  = in_data_reg[7:2];
    assign wdata = in_data_reg[15:8];

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    pfsv_pixel u_pixel (
        .st  (st),
        .res (pres)
    );

    pfsv_regfile u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_valid),
        .cfg_sel (cfg_index),
        .cfg_val (cfg_data),
        .fire    (fire),
        .op      (op),
        .addr    (addr),
        .wdata   (wdata),
        .hits    (pres.hits),
        .st      (st),
        .wres    (wres)
    );

    // Result assembly.
    always_comb begin
        px            = 9'({1'b0, st.line_cnt} - 9'(BLANK_PIXELS));
        out_data_next = '0;
        case (op)
            OP_TICK: begin
                out_data_next[0]     = 1'b1;
                out_data_next[1]     = pres.blank;
                out_data_next[10:2]  = px;
                out_data_next[18:11] = pres.color;
            end
            OP_WRITE: begin
                out_data_next[27]    = wres.frame_sync;
                out_data_next[34:28] = wres.stall;
            end
            OP_READ: begin
                out_data_next[26:19] = read_byte(st.coll, addr[3:0],
                                                 in_data_reg[16], in_data_reg[17]);
            end
            default: ;
        endcase
        in_valid_next  = (in_valid_reg && !fire) || s_tvalid;
        out_valid_next = fire || (out_valid_reg && !m_tready);
    end

    // Stream stage registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= in_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[17:0];
        end
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    `PFSV_ASSERT_IMPL(a_line_range, 1'b1, st.line_cnt < 8'(LINE_PIXELS), "line counter out of range")
    `PFSV_ASSERT_NEXT(a_fire_result, fire, out_valid_reg, "processed item gave no result")
    `PFSV_ASSERT_IMPL(a_nonpixel_zero, out_valid_reg && !out_data_reg[0], out_data_reg[18:1] == 18'd0, "pixel fields set on non-tick")
    `PFSV_ASSERT_IMPL(a_stall_range, out_valid_reg, out_data_reg[34:28] <= 7'd76, "stall count too large")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the playfield and sprite video generator
// Streams pixel ticks, register writes and reads through the block, predicts
// every result with an independent video model and checks each field.
// ----------------------------------------------------------------------------
module tb;
    import pfsv_pkg::*;

    // Result field layout in m_tdata, lowest bit first.
    localparam int NFIELDS = 7;
    localparam int FLD_LO[NFIELDS] = '{0, 1, 2, 11, 19, 27, 28};
    localparam int FLD_W[NFIELDS]  = '{1, 1, 9, 8, 8, 1, 7};
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_CYCLES     = 300;

    // Video model and store of expected result words.
    class video_scoreboard;
        logic [3:0]  ofs_player, ofs_small;
        int          hcount;
        logic [39:0] pf;
        bit          mirror, score, pf_over;
        logic [7:0]  colour[4];
        int          p_pos[2], m_pos[2], b_pos;
        logic [7:0]  shape[2], held[2];
        bit          refl[2], vdel[2], m_en[2];
        logic [8:0]  copies[2];
        int          stretch[2], m_wid[2], b_wid;
        logic [2:0]  b_flags;
        logic [3:0]  motion[5];
        logic [1:0]  sync;
        logic [14:0] coll;
        logic [39:0] pending[$];
        int          errors;

        function new();
            ofs_player = 0; ofs_small = 0; hcount = 0; pf = 0;
            mirror = 0; score = 0; pf_over = 0;
            for (int i = 0; i < 4; i++) colour[i] = 0;
            for (int k = 0; k < 2; k++) begin
                p_pos[k] = 0; m_pos[k] = 0; shape[k] = 0; held[k] = 0;
                refl[k] = 0; vdel[k] = 0; m_en[k] = 0; copies[k] = 0;
                stretch[k] = 1; m_wid[k] = 1;
            end
            for (int i = 0; i < 5; i++) motion[i] = 0;
            b_pos = 0; b_wid = 1; b_flags = 0; sync = 0; coll = 0; errors = 0;
        endfunction

        function void rebuild_pf();
            logic [19:0] left, right;
            left = pf[19:0];
            for (int i = 0; i < 20; i++) right[19 - i] = left[i];
            pf = {mirror ? right : left, left};
        endfunction

        function bit player_on(int k, int x);
            int d, i, sh;
            logic [7:0] shown;
            d = x - p_pos[k];
            shown = vdel[k] ? held[k] : shape[k];
            if (d < 0) return 0;
            if (copies[k] == 0) begin
                sh = stretch[k] == 4 ? 2 : (stretch[k] == 2 ? 1 : 0);
                if (d >= (8 << sh)) return 0;
                i = d >> sh;
            end else begin
                if (d / 8 >= 9 || !copies[k][d / 8]) return 0;
                i = d % 8;
            end
            return refl[k] ? shown[i] : shown[7 - i];
        endfunction

        function bit missile_on(int k, int x);
            int d;
            d = x - m_pos[k];
            if (!m_en[k] || d < 0) return 0;
            if (copies[k] == 0) return d < m_wid[k];
            if (d / 8 >= 9 || !copies[k][d / 8]) return 0;
            return (d % 8) < m_wid[k];
        endfunction

        function int strobe_pos(int fudge, logic [3:0] ofs);
            if (hcount - BLANK_PIXELS < 0) return fudge;
            return (hcount - BLANK_PIXELS + ofs) & 9'h1FF;
        endfunction

        function int shifted(int pos, logic [3:0] nib);
            int v;
            v = (pos - $signed(nib)) % VISIBLE_PIXELS;
            if (v < 0) v += VISIBLE_PIXELS;
            return v;
        endfunction

        // Pixel tick: picks the colour by priority and latches collisions.
        function logic [39:0] tick();
            logic [39:0] r;
            int x;
            bit p0, p1, m0, m1, bl, pfon;
            logic [7:0] pfc, col;
            logic [14:0] hit;
            r = 0; col = 0;
            x = hcount - BLANK_PIXELS;
            r[0] = 1;
            r[10:2] = x[8:0];
            if (sync[1]) begin
                r[1] = 1;
            end else begin
                p0 = player_on(0, x); p1 = player_on(1, x);
                m0 = missile_on(0, x); m1 = missile_on(1, x);
                bl = (b_flags[2] ? b_flags[1] : b_flags[0]) && x >= b_pos
                     && x - b_pos < b_wid;
                pfon = x >= 0 && x / 4 < 40 && pf[x / 4];
                pfc = score ? (x < HALF_PIXELS ? colour[0] : colour[1]) : colour[2];
                hit = {m0 && m1, p0 && p1, bl && pfon, m1 && bl, m1 && pfon, m0 && bl,
                       m0 && pfon, p1 && bl, p1 && pfon, p0 && bl, p0 && pfon,
                       m1 && p1, m1 && p0, m0 && p0, m0 && p1};
                coll |= hit;
                if (pf_over && pfon) col = pfc;
                else if (pf_over && bl) col = colour[2];
                else if (p0 || m0) col = colour[0];
                else if (p1 || m1) col = colour[1];
                else if (pfon) col = pfc;
                else if (bl) col = colour[2];
                else col = colour[3];
            end
            r[18:11] = col;
            hcount = (hcount + 1) % LINE_PIXELS;
            return r;
        endfunction

        function logic [39:0] reg_write(logic [5:0] a, logic [7:0] v);
            logic [39:0] r;
            int k, s;
            r = 0;
            case (a) inside
                A_VSYNC: begin
                    if (sync[0] && !v[1]) r[27] = 1;
                    sync[0] = v[1];
                end
                A_VBLANK: sync[1] = v[1];
                A_WSYNC: if (hcount != 0) begin
                    s = (LINE_PIXELS - hcount) / 3;
                    r[34:28] = s > 127 ? 127 : s;
                end
                A_RSYNC: hcount = LINE_PIXELS - 3;
                A_NUSIZ0, A_NUSIZ1: begin
                    k = a - A_NUSIZ0;
                    m_wid[k] = 1 << v[5:4];
                    case (v[2:0])
                        3'd1: copies[k] = 9'h005;
                        3'd2: copies[k] = 9'h011;
                        3'd3: copies[k] = 9'h015;
                        3'd4: copies[k] = 9'h101;
                        3'd6: copies[k] = 9'h111;
                        default: copies[k] = 0;
                    endcase
                    stretch[k] = v[2:0] == 5 ? 2 : (v[2:0] == 7 ? 4 : 1);
                end
                [A_COLUP0:A_COLUBK]: colour[a - A_COLUP0] = v;
                A_CTRLPF: begin
                    mirror = v[0]; score = v[1]; pf_over = v[2];
                    b_wid = 1 << v[5:4];
                    rebuild_pf();
                end
                A_REFP0, A_REFP1: refl[a - A_REFP0] = v[3];
                A_PF0: begin pf[3:0] = v[7:4]; rebuild_pf(); end
                A_PF1: begin
                    for (int i = 0; i < 8; i++) pf[11 - i] = v[i];
                    rebuild_pf();
                end
                A_PF2: begin pf[19:12] = v; rebuild_pf(); end
                A_RESP0, A_RESP1: p_pos[a - A_RESP0] = strobe_pos(3, ofs_player);
                A_RESM0, A_RESM1: m_pos[a - A_RESM0] = strobe_pos(2, ofs_small);
                A_RESBL: b_pos = strobe_pos(2, ofs_small);
                A_GRP0: begin shape[0] = v; held[1] = shape[1]; end
                A_GRP1: begin
                    shape[1] = v; held[0] = shape[0]; b_flags[1] = b_flags[0];
                end
                A_ENAM0, A_ENAM1: m_en[a - A_ENAM0] = v[1];
                A_ENABL: b_flags[0] = v[1];
                [A_HMP0:A_HMBL]: motion[a - A_HMP0] = v[7:4];
                A_VDELP0, A_VDELP1: vdel[a - A_VDELP0] = v[1];
                A_VDELBL: b_flags[2] = v[1];
                A_RESMP0, A_RESMP1: begin
                    k = a - A_RESMP0;
                    if (v[1]) m_pos[k] = (p_pos[k] + (stretch[k] == 4 ? 10 :
                                          (stretch[k] == 2 ? 6 : 3))) & 9'h1FF;
                end
                A_HMOVE: begin
                    for (int i = 0; i < 2; i++) begin
                        p_pos[i] = shifted(p_pos[i], motion[i]);
                        m_pos[i] = shifted(m_pos[i], motion[2 + i]);
                    end
                    b_pos = shifted(b_pos, motion[4]);
                end
                A_HMCLR: for (int i = 0; i < 5; i++) motion[i] = 0;
                A_CXCLR: coll = 0;
                default: ;
            endcase
            return r;
        endfunction

        function logic [7:0] reg_read(logic [3:0] a, bit f0, bit f1);
            logic [7:0] r;
            r = 0;
            if (a < 8) begin
                r = 8'h02;
                r[7] = coll[a == 7 ? 13 : 2 * a];
                r[6] = a == 6 ? 1'b0 : coll[a == 7 ? 14 : 2 * a + 1];
            end else if (a == R_INPT4) begin
                r[7] = !f0;
            end else if (a == R_INPT5) begin
                r[7] = !f1;
            end
            return r;
        endfunction

        // Called on each accepted input request.
        function void note_request(logic [23:0] d);
            logic [39:0] r;
            r = 0;
            case (d[1:0])
                OP_TICK:  r = tick();
                OP_WRITE: r = reg_write(d[7:2], d[15:8]);
                OP_READ:  r[26:19] = reg_read(d[5:2], d[16], d[17]);
                default:  ;
            endcase
            pending.push_back(r);
        endfunction

        // Called on each accepted result.
        function void check_result(logic [39:0] got);
            logic [39:0] want;
            int e, a;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result expected none actual %h", $time, got);
                return;
            end
            want = pending.pop_front();
            for (int f = 0; f < NFIELDS; f++) begin
                e = (want >> FLD_LO[f]) & ((1 << FLD_W[f]) - 1);
                a = (got >> FLD_LO[f]) & ((1 << FLD_W[f]) - 1);
                if (e != a) begin
                    errors++;
                    $display("%0t: field %0d mismatch expected %h actual %h",
                             $time, f, e, a);
                end
            end
            if (got[39:35] != 0) begin
                errors++;
                $display("%0t: padding expected 0 actual %h", $time, got[39:35]);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_index = 0;
    logic [3:0]  cfg_data = 0;

    video_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    playfield_sprite_video_generator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Receiver: random stalls, plus one long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
            m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Watchdog on cycles without any accepted request, accepted result or configuration write.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(logic [1:0] op, logic [5:0] addr, logic [7:0] data,
                                bit f0, bit f1);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, f1, f0, data, addr, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(s_tdata);
    endtask

    task automatic write_offsets(logic [3:0] player, logic [3:0] small_obj);
        cfg_valid <= 1;
        cfg_index <= CFG_PLAYER_OFS;
        cfg_data <= player;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.ofs_player = player;
        cfg_index <= CFG_SMALL_OFS;
        cfg_data <= small_obj;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.ofs_small = small_obj;
        cfg_valid <= 0;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_requests(int count, bit pressure);
        logic [1:0] op;
        logic [5:0] addr;
        logic [7:0] data;
        int pick;
        for (int n = 0; n < count; n++) begin
            if (pressure && n == count / 3) hold_req = 1;
            pick = $urandom_range(99);
            addr = 6'($urandom);
            data = 8'($urandom);
            if (pick < 65) begin
                op = OP_TICK;
            end else if (pick < 90) begin
                op = OP_WRITE;
                if ($urandom_range(9) != 0) addr = 6'($urandom_range(44));
                // Keep vertical blank off most of the time so pixels get drawn.
                if (addr == A_VBLANK && $urandom_range(3) != 0) data[1] = 0;
            end else if (pick < 98) begin
                op = OP_READ;
            end else begin
                op = 2'd3;
            end
            send_request(op, addr, data, 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part with no idling.
        write_offsets(4'd0, 4'd0);
        send_request(OP_WRITE, A_VSYNC, 8'h02, 0, 0);
        send_request(OP_WRITE, A_VSYNC, 8'h00, 0, 0);
        send_request(OP_WRITE, A_VBLANK, 8'hFF, 0, 0);
        send_request(OP_TICK, 6'd0, 8'd0, 0, 0);
        send_request(OP_WRITE, A_VBLANK, 8'h00, 0, 0);
        send_request(OP_WRITE, A_WSYNC, 8'h00, 0, 0);
        send_request(OP_WRITE, A_RSYNC, 8'h00, 0, 0);
        send_request(OP_WRITE, A_RESP0, 8'h00, 0, 0);
        send_request(OP_TICK, 6'd0, 8'd0, 0, 0);
        send_request(OP_TICK, 6'd0, 8'd0, 0, 0);
        send_request(OP_TICK, 6'd0, 8'd0, 0, 0);
        send_request(OP_WRITE, A_WSYNC, 8'h00, 0, 0);
        send_request(OP_WRITE, A_PF0, 8'hFF, 0, 0);
        send_request(OP_WRITE, A_CTRLPF, 8'hFF, 0, 0);
        send_request(OP_WRITE, A_GRP0, 8'hFF, 0, 0);
        send_request(OP_WRITE, A_HMOVE, 8'h00, 0, 0);
        send_request(OP_READ, 6'd2, 8'h00, 1, 0);
        send_request(OP_READ, R_INPT4, 8'h00, 1, 1);
        send_request(OP_READ, 6'h3F, 8'h00, 0, 0);
        send_request(OP_WRITE, 6'h3F, 8'hFF, 0, 0);
        send_request(OP_WRITE, A_CXCLR, 8'h00, 0, 0);
        send_request(2'd3, 6'h3F, 8'hFF, 1, 1);
        random_requests(50, 0);
        drain();

        // Random phases with different idling and offset settings.
        write_offsets(4'd15, 4'd15);
        send_idle_pct = 82; recv_stall_pct = 0;
        random_requests(250, 0);
        drain();
        write_offsets(4'd7, 4'd3);
        send_idle_pct = 0; recv_stall_pct = 82;
        random_requests(250, 0);
        drain();
        write_offsets(4'($urandom), 4'($urandom));
        send_idle_pct = 15; recv_stall_pct = 15;
        random_requests(250, 1);
        drain();
        write_offsets(4'd0, 4'd15);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_requests(200, 0);
        drain();

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
